>>> hw/rtl/tcpq_pkg.sv
// Shared constants, codes and structs for the two-class priority job queue.
// Used by tcpq_ctrl, two_class_priority_job_queue_unit and the bench.
package tcpq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W     = TAG_BITS + 1;

   // field widths fixed by the interface
   localparam int POL_W    = 2;
   localparam int CAP_W    = 5;
   localparam int OCC_W    = 5;
   localparam int DISP_W   = 32;
   localparam int JOB_W    = 32;
   localparam int CMP_W    = (CAP_W > CNT_W + 1) ? CAP_W : CNT_W + 1;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 80;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // scheduling policies
   localparam logic [POL_W-1:0] POL_ANY  = 2'd0;
   localparam logic [POL_W-1:0] POL_FIFO = 2'd1;
   localparam logic [POL_W-1:0] POL_HPIC = 2'd2;
   localparam logic [POL_W-1:0] POL_HPHC = 2'd3;

   // request kinds
   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   // register indexes (address bit 2)
   localparam logic REG_POLICY   = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   // register reset values
   localparam logic [POL_W-1:0] POLICY_RST   = POL_FIFO;
   localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

   // memory accesses issued for one item
   typedef struct packed {
      logic               h_wr_en;
      logic [PTR_W-1:0]   h_wr_addr;
      logic               l_wr_en;
      logic [PTR_W-1:0]   l_wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               h_rd_en;
      logic [PTR_W-1:0]   h_rd_addr;
      logic               l_rd_en;
      logic [PTR_W-1:0]   l_rd_addr;
   } mem_ctl_type;

   // per-item result fields known at acceptance
   typedef struct packed {
      logic              accepted;
      logic              job_valid;
      logic              from_high;
      logic [DISP_W-1:0] dispatch_number;
      logic [OCC_W-1:0]  occupancy;
   } step_info_type;

   // ring pointer advance with wrap
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

>>> hw/rtl/tcpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tcpq_ctrl.sv
// Queue control: ring pointers, counts, dispatch counter and routing policy.
// Issues the memory accesses for each item. Depends on tcpq_pkg.
module tcpq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          mode,
   input  logic [tcpq_pkg::JOB_W-1:0]    job_tag,
   input  logic                          is_image,
   input  logic [tcpq_pkg::POL_W-1:0]    policy,
   input  logic [tcpq_pkg::CAP_W-1:0]    capacity,
   output tcpq_pkg::mem_ctl_type         mem_ctl,
   output tcpq_pkg::step_info_type       info
);
   import tcpq_pkg::*;

   logic [PTR_W-1:0]  h_head_ff, h_head_in, h_tail_ff, h_tail_in;
   logic [PTR_W-1:0]  l_head_ff, l_head_in, l_tail_ff, l_tail_in;
   logic [CNT_W-1:0]  h_cnt_ff, h_cnt_in, l_cnt_ff, l_cnt_in;
   logic [DISP_W-1:0] disp_ff, disp_in;
   logic [CMP_W-1:0]  total, limit, cap_ext, total_after;
   logic              to_high, has_room;

   // limit saturates at the queue depth
   always_comb begin
      cap_ext  = CMP_W'(capacity);
      limit    = (cap_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : cap_ext;
      total    = CMP_W'(h_cnt_ff) + CMP_W'(l_cnt_ff);
      has_room = (total < limit);
      to_high  = ((policy == POL_HPIC) && is_image) ||
                 ((policy == POL_HPHC) && !is_image);
   end

   // next state and memory accesses
   always_comb begin
      h_head_in   = h_head_ff;
      h_tail_in   = h_tail_ff;
      l_head_in   = l_head_ff;
      l_tail_in   = l_tail_ff;
      h_cnt_in    = h_cnt_ff;
      l_cnt_in    = l_cnt_ff;
      disp_in     = disp_ff;
      total_after = total;

      mem_ctl           = '0;
      mem_ctl.h_wr_addr = h_tail_ff;
      mem_ctl.l_wr_addr = l_tail_ff;
      mem_ctl.h_rd_addr = h_head_ff;
      mem_ctl.l_rd_addr = l_head_ff;
      mem_ctl.wr_data   = {is_image, TAG_BITS'(job_tag)};

      info                 = '0;
      info.dispatch_number = '0;

      if (accept) begin
         if (mode == MODE_ENQ) begin
            if (has_room) begin
               info.accepted = 1'b1;
               total_after   = total + 1'b1;
               if (to_high) begin
                  mem_ctl.h_wr_en = 1'b1;
                  h_tail_in       = next_ptr(h_tail_ff);
                  h_cnt_in        = h_cnt_ff + 1'b1;
               end else begin
                  mem_ctl.l_wr_en = 1'b1;
                  l_tail_in       = next_ptr(l_tail_ff);
                  l_cnt_in        = l_cnt_ff + 1'b1;
               end
            end
         end else begin
            if (h_cnt_ff != '0) begin
               mem_ctl.h_rd_en = 1'b1;
               h_head_in       = next_ptr(h_head_ff);
               h_cnt_in        = h_cnt_ff - 1'b1;
               info.from_high  = 1'b1;
               info.job_valid  = 1'b1;
            end else if (l_cnt_ff != '0) begin
               mem_ctl.l_rd_en = 1'b1;
               l_head_in       = next_ptr(l_head_ff);
               l_cnt_in        = l_cnt_ff - 1'b1;
               info.job_valid  = 1'b1;
            end
            if (info.job_valid) begin
               info.dispatch_number = disp_ff;
               disp_in              = disp_ff + 1'b1;
               total_after          = total - 1'b1;
            end
         end
      end
      info.occupancy = OCC_W'(total_after);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         h_head_ff <= '0;
         h_tail_ff <= '0;
         l_head_ff <= '0;
         l_tail_ff <= '0;
         h_cnt_ff  <= '0;
         l_cnt_ff  <= '0;
         disp_ff   <= '0;
      end else begin
         h_head_ff <= h_head_in;
         h_tail_ff <= h_tail_in;
         l_head_ff <= l_head_in;
         l_tail_ff <= l_tail_in;
         h_cnt_ff  <= h_cnt_in;
         l_cnt_ff  <= l_cnt_in;
         disp_ff   <= disp_in;
      end
   end

   // combined count never passes the queue depth
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total <= CMP_W'(QUEUE_DEPTH))
      else $error("combined job count above queue depth");

   // an item never both writes and reads the store
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !((mem_ctl.h_wr_en || mem_ctl.l_wr_en) && (mem_ctl.h_rd_en || mem_ctl.l_rd_en)))
      else $error("item issued both a write and a read");

   // a delivered job advances the dispatch counter by one
   a_disp_step: assert property (@(posedge clock) disable iff (reset)
      info.job_valid |=> disp_ff == $past(disp_ff) + 1'b1)
      else $error("dispatch counter did not advance");

   // a stored high job bumps the high count
   a_high_cnt: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.h_wr_en |=> h_cnt_ff == $past(h_cnt_ff) + 1'b1)
      else $error("high count did not follow the write");

endmodule

>>> hw/rtl/two_class_priority_job_queue_unit.sv
// Top level of the two-class strict-priority job queue.
// Holds config registers, result staging and the two queue stores.
// Depends on tcpq_pkg, tcpq_ram and tcpq_ctrl.
//
//   port group  | role                  | contents
//   req_*       | item in (stream)      | tuser: mode; tdata: job_tag, is_image
//   rsp_*       | result out (stream)   | tdata: accepted .. occupancy
//   csr_*       | config (APB-style)    | policy at 0x0, capacity at 0x4
//
// one item per cycle sustained while the result stream is not stalled; each
// result is staged alongside its registered queue store read, then moved to the output register
// reset clears pointers, counts and the dispatch counter; the stores are not
// cleared and hold no valid bits
// a stalled result holds in the output register while one more item waits
// in the staging register; input stalls only when both are full
module two_class_priority_job_queue_unit (
   input  logic                         clock,
   input  logic                         reset,
   // request stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tcpq_pkg::REQ_W-1:0]   req_tdata,  // job_tag[31:0], is_image[32], zero pad
   input  logic                         req_tuser,  // mode[0]
   // result stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // accepted[0], job_valid[1], out_tag[33:2], out_is_image[34], from_high[35],
   // dispatch_number[67:36], occupancy[72:68], zero pad
   output logic [tcpq_pkg::RSP_W-1:0]   rsp_tdata,
   // config port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tcpq_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [tcpq_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [tcpq_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import tcpq_pkg::*;

   logic [POL_W-1:0]   policy_ff, policy_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic               cfg_wr;

   logic               accept, pend_move;
   logic               pend_valid_ff, pend_valid_in;
   step_info_type      pend_info_ff, pend_info_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   mem_ctl_type        mem_ctl;
   step_info_type      info;
   logic [ENTRY_W-1:0] h_rd_data, l_rd_data, sel_entry;
   logic [JOB_W-1:0]   out_tag;
   logic               out_img;

   // config port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      policy_in   = policy_ff;
      capacity_in = capacity_ff;
      if (cfg_wr) begin
         case (csr_paddr[2])
            REG_POLICY:   policy_in   = csr_pwdata[POL_W-1:0];
            REG_CAPACITY: capacity_in = csr_pwdata[CAP_W-1:0];
            default:      policy_in   = policy_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_POLICY:   csr_prdata = CSR_DW'(policy_ff);
         REG_CAPACITY: csr_prdata = CSR_DW'(capacity_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POLICY_RST;
         capacity_ff <= CAPACITY_RST;
      end else begin
         policy_ff   <= policy_in;
         capacity_ff <= capacity_in;
      end
   end

   // handshake: staging slot frees when the output register can take it
   assign pend_move  = pend_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_valid_ff || pend_move;
   assign accept     = req_tvalid && req_tready;

   // queue control
   tcpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .mode     (req_tuser),
      .job_tag  (req_tdata[JOB_W-1:0]),
      .is_image (req_tdata[JOB_W]),
      .policy   (policy_ff),
      .capacity (capacity_ff),
      .mem_ctl  (mem_ctl),
      .info     (info)
   );

   // queue stores
   tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_high_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.h_wr_en),
      .wr_addr (mem_ctl.h_wr_addr),
      .wr_data (mem_ctl.wr_data),
      .rd_en   (mem_ctl.h_rd_en),
      .rd_addr (mem_ctl.h_rd_addr),
      .rd_data (h_rd_data)
   );

   tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_low_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.l_wr_en),
      .wr_addr (mem_ctl.l_wr_addr),
      .wr_data (mem_ctl.wr_data),
      .rd_en   (mem_ctl.l_rd_en),
      .rd_addr (mem_ctl.l_rd_addr),
      .rd_data (l_rd_data)
   );

   // staging slot for the item whose store read is in flight
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_info_in  = pend_info_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
         pend_info_in  = info;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
   end

   // result assembly from the store read data
   always_comb begin
      sel_entry = pend_info_ff.from_high ? h_rd_data : l_rd_data;
      out_tag   = pend_info_ff.job_valid ? JOB_W'(sel_entry[TAG_BITS-1:0]) : '0;
      out_img   = pend_info_ff.job_valid && sel_entry[TAG_BITS];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({pend_info_ff.occupancy,
                                pend_info_ff.dispatch_number,
                                pend_info_ff.from_high,
                                out_img,
                                out_tag,
                                pend_info_ff.job_valid,
                                pend_info_ff.accepted});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // staging and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_info_ff <= pend_info_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a staged item that cannot move means the output is occupied
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !pend_move) |-> rsp_valid_ff)
      else $error("staged item blocked with empty output");

   // a result never flags both a stored and a returned job
   a_excl_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[0] && rsp_data_ff[1]))
      else $error("result marks both enqueue and dequeue");

   // a staged item reaches the output register in the next cycle when it moves
   a_move_load: assert property (@(posedge clock) disable iff (reset)
      pend_move |=> rsp_valid_ff)
      else $error("moved item missing from output register");

endmodule

>>> tb/tb.sv
// Self-checking bench for two_class_priority_job_queue_unit: directed and random
// enqueue/dequeue traffic under every policy and several capacities.
// Depends on tcpq_pkg and the RTL of the unit; needs no other files.
module tb;
   import tcpq_pkg::*;

   localparam int HOLD_CYCLES = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int BATCH_ITEMS = 100;
   localparam int NUM_BATCHES = 12;

   // one request as queued for the driver
   typedef struct {
      logic        mode;
      logic [31:0] tag;
      logic        img;
   } job_req_type;

   // one result as predicted
   typedef struct packed {
      logic        accepted;
      logic        job_valid;
      logic [31:0] out_tag;
      logic        out_is_image;
      logic        from_high;
      logic [31:0] dispatch_number;
      logic [4:0]  occupancy;
   } job_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;  // job_tag[31:0], is_image[32], zero pad
   logic              req_tuser = 1'b0;  // mode[0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // accepted[0], job_valid[1], out_tag[33:2], out_is_image[34], from_high[35],
   // dispatch_number[67:36], occupancy[72:68], zero pad
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   two_class_priority_job_queue_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // scheduler mirror: config shadows, two rings, counts
   logic [POL_W-1:0] cfg_policy   = POLICY_RST;
   logic [CAP_W-1:0] cfg_capacity = CAPACITY_RST;
   logic [31:0]      hi_tag [QUEUE_DEPTH];
   logic             hi_img [QUEUE_DEPTH];
   logic [31:0]      lo_tag [QUEUE_DEPTH];
   logic             lo_img [QUEUE_DEPTH];
   int               hi_head = 0, hi_tail = 0, hi_count = 0;
   int               lo_head = 0, lo_tail = 0, lo_count = 0;
   logic [31:0]      dispatch_seq = '0;

   job_req_type   pending_jobs [$];
   job_reply_type job_replies_due [$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int mismatches = 0;
   int csr_mismatches = 0;
   int items_sent = 0;
   int refused_count = 0;
   int dispatched_hi = 0;
   int dispatched_lo = 0;
   int empty_dequeues = 0;
   int cycle_count = 0;

   // expected result of one accepted item, state updated as the block would
   task automatic schedule_job(input logic mode, input logic [31:0] tag, input logic img);
      job_reply_type r;
      logic          to_high;
      int            limit;
      r = '0;
      limit = (int'(cfg_capacity) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cfg_capacity);
      if (mode == MODE_ENQ) begin
         if (hi_count + lo_count < limit) begin
            to_high = (cfg_policy == POL_HPIC && img) || (cfg_policy == POL_HPHC && !img);
            if (to_high) begin
               hi_tag[hi_tail] = tag;
               hi_img[hi_tail] = img;
               hi_tail = (hi_tail + 1) % QUEUE_DEPTH;
               hi_count++;
            end else begin
               lo_tag[lo_tail] = tag;
               lo_img[lo_tail] = img;
               lo_tail = (lo_tail + 1) % QUEUE_DEPTH;
               lo_count++;
            end
            r.accepted = 1'b1;
         end else begin
            refused_count++;
         end
      end else begin
         // strict priority: high ring first
         if (hi_count > 0) begin
            r.out_tag = hi_tag[hi_head];
            r.out_is_image = hi_img[hi_head];
            r.from_high = 1'b1;
            r.job_valid = 1'b1;
            hi_head = (hi_head + 1) % QUEUE_DEPTH;
            hi_count--;
            dispatched_hi++;
         end else if (lo_count > 0) begin
            r.out_tag = lo_tag[lo_head];
            r.out_is_image = lo_img[lo_head];
            r.job_valid = 1'b1;
            lo_head = (lo_head + 1) % QUEUE_DEPTH;
            lo_count--;
            dispatched_lo++;
         end else begin
            empty_dequeues++;
         end
         if (r.job_valid) begin
            r.dispatch_number = dispatch_seq;
            dispatch_seq = dispatch_seq + 32'd1;
         end
      end
      r.occupancy = 5'(hi_count + lo_count);
      job_replies_due.push_back(r);
   endtask

   // request driver
   always @(posedge clock) begin
      job_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            schedule_job(req_tuser, req_tdata[31:0], req_tdata[32]);
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_jobs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               nxt = pending_jobs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.mode;
               req_tdata <= {7'b0, nxt.img, nxt.tag};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic int field_bad(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
         return 1;
      end
      return 0;
   endfunction

   // result monitor and receiver stalls
   always @(posedge clock) begin
      job_reply_type want;
      job_reply_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.accepted        = rsp_tdata[0];
            got.job_valid       = rsp_tdata[1];
            got.out_tag         = rsp_tdata[33:2];
            got.out_is_image    = rsp_tdata[34];
            got.from_high       = rsp_tdata[35];
            got.dispatch_number = rsp_tdata[67:36];
            got.occupancy       = rsp_tdata[72:68];
            if (job_replies_due.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = job_replies_due.pop_front();
               mismatches += field_bad("accepted", want.accepted, got.accepted);
               mismatches += field_bad("job_valid", want.job_valid, got.job_valid);
               mismatches += field_bad("out_tag", want.out_tag, got.out_tag);
               mismatches += field_bad("out_is_image", want.out_is_image, got.out_is_image);
               mismatches += field_bad("from_high", want.from_high, got.from_high);
               mismatches += field_bad("dispatch_number", want.dispatch_number,
                                       got.dispatch_number);
               mismatches += field_bad("occupancy", want.occupancy, got.occupancy);
            end
         end
         // long hold-off on request, else random stalls
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic queue_item(input logic mode, input logic [31:0] tag, input logic img);
      job_req_type it;
      it.mode = mode;
      it.tag = tag;
      it.img = img;
      pending_jobs.push_back(it);
   endtask

   // wait until every item is taken and answered, then let the pipe settle
   task automatic wait_drained();
      while (pending_jobs.size() != 0 || req_tvalid || job_replies_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DW-1:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_POLICY) cfg_policy = val[POL_W-1:0];
      else cfg_capacity = val[CAP_W-1:0];
   endtask

   task automatic csr_check(input logic idx);
      logic [CSR_DW-1:0] want;
      want = (idx == REG_POLICY) ? CSR_DW'(cfg_policy) : CSR_DW'(cfg_capacity);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== want) begin
         $display("%0t: register %0d readback mismatch, expected %h actual %h",
                  $time, idx, want, csr_prdata);
         csr_mismatches++;
      end
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic [POL_W-1:0] pol, input logic [CAP_W-1:0] cap);
      wait_drained();
      csr_write(REG_POLICY, CSR_DW'(pol));
      csr_write(REG_CAPACITY, CSR_DW'(cap));
      csr_check(REG_POLICY);
      csr_check(REG_CAPACITY);
   endtask

   // random batch settings: extremes of capacity, every policy
   logic [POL_W-1:0] batch_pol [NUM_BATCHES] = '{POL_ANY, POL_FIFO, POL_HPIC, POL_HPHC,
                                                 POL_HPIC, POL_HPHC, POL_FIFO, POL_ANY,
                                                 POL_HPIC, POL_HPHC, POL_HPIC, POL_HPHC};
   int batch_cap [NUM_BATCHES] = '{16, 31, 8, 17, 1, 16, 5, 0, 31, 2, 16, -1};
   int batch_enq [NUM_BATCHES] = '{60, 75, 55, 65, 50, 45, 60, 50, 80, 55, 35, 55};

   // main sequence
   initial begin
      int cap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values, empty dequeue, tag extremes
      csr_check(REG_POLICY);
      csr_check(REG_CAPACITY);
      queue_item(MODE_DEQ, 32'h0, 1'b0);
      queue_item(MODE_ENQ, 32'h0000_0000, 1'b0);
      queue_item(MODE_ENQ, 32'hFFFF_FFFF, 1'b1);
      queue_item(MODE_DEQ, 32'hFFFF_FFFF, 1'b1);
      queue_item(MODE_DEQ, 32'h0, 1'b0);
      queue_item(MODE_DEQ, 32'h0, 1'b0);

      // images first, small limit: refusal when full, high served first
      set_config(POL_HPIC, 5'd3);
      queue_item(MODE_ENQ, 32'h5555_5555, 1'b1);
      queue_item(MODE_ENQ, 32'hAAAA_AAAA, 1'b0);
      queue_item(MODE_ENQ, 32'h0000_0001, 1'b1);
      queue_item(MODE_ENQ, 32'h0000_0002, 1'b0);
      queue_item(MODE_DEQ, 32'h0, 1'b0);
      queue_item(MODE_DEQ, 32'h0, 1'b0);
      queue_item(MODE_DEQ, 32'h0, 1'b0);
      queue_item(MODE_DEQ, 32'h0, 1'b0);

      // zero capacity refuses everything
      set_config(POL_HPHC, 5'd0);
      queue_item(MODE_ENQ, 32'h0000_0007, 1'b0);
      queue_item(MODE_ENQ, 32'h8000_0000, 1'b1);
      queue_item(MODE_DEQ, 32'h0, 1'b0);

      // any policy, single slot
      set_config(POL_ANY, 5'd1);
      queue_item(MODE_ENQ, 32'h1234_5678, 1'b0);
      queue_item(MODE_ENQ, 32'h8765_4321, 1'b1);
      queue_item(MODE_DEQ, 32'h0, 1'b0);

      // random batches in three idling phases
      for (int b = 0; b < NUM_BATCHES; b++) begin
         cap = (batch_cap[b] < 0) ? $urandom_range(16, 1) : batch_cap[b];
         set_config(batch_pol[b], CAP_W'(cap));
         if (b < 4) begin
            tx_idle_pct = 21;
            rx_idle_pct = 73;
         end else if (b < 8) begin
            tx_idle_pct = 73;
            rx_idle_pct = 21;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         for (int i = 0; i < BATCH_ITEMS; i++)
            queue_item(($urandom_range(99) < batch_enq[b]) ? MODE_ENQ : MODE_DEQ,
                       $urandom(), 1'($urandom_range(1)));
         // receiver holds off while the sender keeps offering
         if (b == 8) hold_requests++;
      end

      wait_drained();
      repeat (8) @(negedge clock);
      $display("covered %0d items: %0d refused enqueues, %0d empty dequeues",
               items_sent, refused_count, empty_dequeues);
      $display("dispatched %0d jobs from high ring and %0d from low ring",
               dispatched_hi, dispatched_lo);
      if (mismatches == 0 && csr_mismatches == 0 && job_replies_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
